@@ src/irsa_pkg.sv @@
// Package for insert_remove_sort_array: sizes, mode and status codes,
// per-cell operation codes, control and result structs, word conversions.
// No dependencies; every other file refers to it by scoped names.
package irsa_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  // Port field widths are fixed at 5 bits; internal compares use the wider of the two.
  localparam int LEN_BITS  = $clog2(DEPTH + 1);
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int PORT_BITS = 5;
  localparam int CMP_BITS  = (LEN_BITS > PORT_BITS) ? LEN_BITS : PORT_BITS;

  localparam logic [2:0] MODE_WRITE  = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_INSERT = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_PUSH   = 3'd4;
  localparam logic [2:0] MODE_RESIZE = 3'd5;
  localparam logic [2:0] MODE_CLEAR  = 3'd6;
  localparam logic [2:0] MODE_SORT   = 3'd7;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    C_HOLD,
    C_LOAD,
    C_LEFT,
    C_RIGHT,
    C_ZERO,
    C_SORT_LO,
    C_SORT_HI
  } cell_op_e;

  typedef struct packed {
    logic accept;
    logic sort_step;
    logic phase;
  } ctl_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [4:0]  length_now;
    logic [1:0]  status;
  } res_t;

  function automatic logic [WORD_BITS-1:0] word_from_in(input logic signed [31:0] x);
    logic signed [63:0] e;
    e = 64'(x);
    return e[WORD_BITS-1:0];
  endfunction

  function automatic logic [31:0] word_to_out(input logic signed [WORD_BITS-1:0] w);
    logic signed [63:0] e;
    e = 64'(w);
    return e[31:0];
  endfunction

endpackage

@@ src/insert_remove_sort_array.sv @@
// Top level of insert_remove_sort_array: row of irsa_cell storage cells,
// length register, per-cell operation decode and the irsa_ctrl sequencer.
// Depends on irsa_pkg, irsa_cell and irsa_ctrl.
//
//   channel | signals                                            | dir
//   in      | in_valid_i, in_ready_o, mode_i, position_i,        | in
//           | item_value_i, new_length_i                         |
//   out     | out_valid_o, out_ready_i, read_value_o,            | out
//           | length_now_o, status_o                             |
//
// Write, read, insert, remove, push, resize and clear finish in the cycle of
// the input transfer; the result is registered into the result queue.
// Sort runs odd-even compare-exchange passes over the cell row, one pass per
// cycle; no input is taken during the passes.
// Two results can wait for out_ready_i; input stalls while both are held.
// Reset clears all cells, the length and the result queue.
module insert_remove_sort_array (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] item_value_i,
  input  logic [4:0]         new_length_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_value_o,
  output logic [4:0]         length_now_o,
  output logic [1:0]         status_o
);

  localparam int DEPTH = irsa_pkg::DEPTH;
  localparam int WB    = irsa_pkg::WORD_BITS;
  localparam int CB    = irsa_pkg::CMP_BITS;

  logic [irsa_pkg::LEN_BITS-1:0] fill_q, fill_d;
  logic [WB-1:0]                 words [DEPTH];
  logic [WB-1:0]                 left_w [DEPTH];
  logic [WB-1:0]                 right_w [DEPTH];
  irsa_pkg::cell_op_e            ops [DEPTH];
  irsa_pkg::ctl_t                ctl;
  irsa_pkg::res_t                res_now, res_sort, res_out;

  logic [WB-1:0] w_in;
  logic [CB-1:0] pos_c, fill_c, nlen_c, depth_c, new_fill;
  logic [1:0]    status;
  logic [31:0]   rd;
  logic          do_op;
  logic          wr_ok, ins_ok, rem_ok, push_ok, rsz_ok;

  assign w_in    = irsa_pkg::word_from_in(item_value_i);
  assign pos_c   = CB'(position_i);
  assign fill_c  = CB'(fill_q);
  assign nlen_c  = CB'(new_length_i);
  assign depth_c = CB'(DEPTH);
  assign do_op   = ctl.accept && (mode_i != irsa_pkg::MODE_SORT);

  always_comb begin
    status   = irsa_pkg::STAT_OK;
    rd       = '0;
    new_fill = fill_c;
    wr_ok    = 1'b0;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    push_ok  = 1'b0;
    rsz_ok   = 1'b0;
    unique case (mode_i)
      irsa_pkg::MODE_WRITE: begin
        wr_ok = pos_c < fill_c;
        if (!wr_ok) status = irsa_pkg::STAT_RANGE;
      end
      irsa_pkg::MODE_READ: begin
        if (pos_c < fill_c) begin
          rd = irsa_pkg::word_to_out(words[pos_c[irsa_pkg::IDX_BITS-1:0]]);
        end else begin
          status = irsa_pkg::STAT_RANGE;
        end
      end
      irsa_pkg::MODE_INSERT: begin
        if (pos_c > fill_c) begin
          status = irsa_pkg::STAT_RANGE;
        end else if (fill_c == depth_c) begin
          status = irsa_pkg::STAT_FULL;
        end else begin
          ins_ok   = 1'b1;
          new_fill = fill_c + 1'b1;
        end
      end
      irsa_pkg::MODE_REMOVE: begin
        if (pos_c < fill_c) begin
          rem_ok   = 1'b1;
          new_fill = fill_c - 1'b1;
        end else begin
          status = irsa_pkg::STAT_RANGE;
        end
      end
      irsa_pkg::MODE_PUSH: begin
        if (fill_c == depth_c) begin
          status = irsa_pkg::STAT_FULL;
        end else begin
          push_ok  = 1'b1;
          new_fill = fill_c + 1'b1;
        end
      end
      irsa_pkg::MODE_RESIZE: begin
        if (nlen_c > depth_c) begin
          status = irsa_pkg::STAT_RANGE;
        end else begin
          rsz_ok   = 1'b1;
          new_fill = nlen_c;
        end
      end
      irsa_pkg::MODE_CLEAR: new_fill = '0;
      irsa_pkg::MODE_SORT:  new_fill = fill_c;
      default:              new_fill = fill_c;
    endcase
  end

  // per-cell operation: each cell decides from its own index
  always_comb begin
    logic [CB-1:0] kc;
    logic [CB-1:0] k1;
    for (int k = 0; k < DEPTH; k++) begin
      kc     = CB'(k);
      k1     = CB'(k + 1);
      ops[k] = irsa_pkg::C_HOLD;
      if (ctl.sort_step) begin
        if ((kc[0] == ctl.phase) && (k1 < fill_c)) begin
          ops[k] = irsa_pkg::C_SORT_LO;
        end else if ((kc[0] != ctl.phase) && (k > 0) && (kc < fill_c)) begin
          ops[k] = irsa_pkg::C_SORT_HI;
        end
      end else if (do_op) begin
        if (wr_ok && (kc == pos_c)) begin
          ops[k] = irsa_pkg::C_LOAD;
        end else if (ins_ok && (kc == pos_c)) begin
          ops[k] = irsa_pkg::C_LOAD;
        end else if (ins_ok && (kc > pos_c) && (kc <= fill_c)) begin
          ops[k] = irsa_pkg::C_LEFT;
        end else if (rem_ok && (k1 == fill_c)) begin
          ops[k] = irsa_pkg::C_ZERO;
        end else if (rem_ok && (kc >= pos_c) && (k1 < fill_c)) begin
          ops[k] = irsa_pkg::C_RIGHT;
        end else if (push_ok && (kc == fill_c)) begin
          ops[k] = irsa_pkg::C_LOAD;
        end else if (rsz_ok && (kc >= fill_c) && (kc < nlen_c)) begin
          ops[k] = irsa_pkg::C_ZERO;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_mid_r
      assign right_w[g] = words[g+1];
    end

    irsa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (ops[g]),
      .value_i (w_in),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .word_o  (words[g])
    );
  end

  assign fill_d = do_op ? irsa_pkg::LEN_BITS'(new_fill) : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign res_now.read_value  = rd;
  assign res_now.length_now  = new_fill[4:0];
  assign res_now.status      = status;
  assign res_sort.read_value = '0;
  assign res_sort.length_now = fill_c[4:0];
  assign res_sort.status     = irsa_pkg::STAT_OK;

  irsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .is_sort_i   (mode_i == irsa_pkg::MODE_SORT),
    .res_now_i   (res_now),
    .res_sort_i  (res_sort),
    .ctl_o       (ctl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign read_value_o = res_out.read_value;
  assign length_now_o = res_out.length_now;
  assign status_o     = res_out.status;

endmodule

@@ src/irsa_cell.sv @@
// One storage cell of the row: holds a word and picks its next value
// from its own input, its neighbors, zero, or one compare-exchange step.
// Depends on irsa_pkg.
module irsa_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  irsa_pkg::cell_op_e            op_i,
  input  logic [irsa_pkg::WORD_BITS-1:0] value_i,
  input  logic [irsa_pkg::WORD_BITS-1:0] left_i,
  input  logic [irsa_pkg::WORD_BITS-1:0] right_i,
  output logic [irsa_pkg::WORD_BITS-1:0] word_o
);

  logic [irsa_pkg::WORD_BITS-1:0] word_q, word_d;
  logic                           right_lt, self_lt_left;

  assign right_lt     = $signed(right_i) < $signed(word_q);
  assign self_lt_left = $signed(word_q) < $signed(left_i);

  always_comb begin
    word_d = word_q;
    unique case (op_i)
      irsa_pkg::C_HOLD:    word_d = word_q;
      irsa_pkg::C_LOAD:    word_d = value_i;
      irsa_pkg::C_LEFT:    word_d = left_i;
      irsa_pkg::C_RIGHT:   word_d = right_i;
      irsa_pkg::C_ZERO:    word_d = '0;
      // lower cell of a pair keeps the minimum, upper cell the maximum
      irsa_pkg::C_SORT_LO: word_d = right_lt ? right_i : word_q;
      irsa_pkg::C_SORT_HI: word_d = self_lt_left ? left_i : word_q;
      default:             word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

@@ src/irsa_ctrl.sv @@
// Sequencer for insert_remove_sort_array: input handshake, sort pass
// counter and a two-entry result queue (output register plus skid).
// Depends on irsa_pkg.
module irsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            is_sort_i,
  input  irsa_pkg::res_t  res_now_i,
  input  irsa_pkg::res_t  res_sort_i,
  output irsa_pkg::ctl_t  ctl_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output irsa_pkg::res_t  res_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SORT = 1'b1;

  logic                          state_q, state_d;
  logic [irsa_pkg::IDX_BITS-1:0] pass_q, pass_d;
  logic                          out_valid_q, out_valid_d;
  logic                          skid_valid_q, skid_valid_d;
  irsa_pkg::res_t                out_q, out_d, skid_q, skid_d;
  logic                          accept, pass_last, push, pop;
  irsa_pkg::res_t                push_res;

  assign in_ready_o = (state_q == ST_IDLE) && !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign pass_last  = pass_q == irsa_pkg::IDX_BITS'(irsa_pkg::DEPTH - 1);

  assign ctl_o.accept    = accept;
  assign ctl_o.sort_step = state_q == ST_SORT;
  assign ctl_o.phase     = pass_q[0];

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_sort_i) begin
          state_d = ST_SORT;
          pass_d  = '0;
        end
      end
      ST_SORT: begin
        pass_d = pass_q + 1'b1;
        if (pass_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // results enter the queue on a non-sort transfer or at the last sort pass
  assign push     = (accept && !is_sort_i) || ((state_q == ST_SORT) && pass_last);
  assign push_res = (state_q == ST_SORT) ? res_sort_i : res_now_i;
  assign pop      = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d = skid_q;
        if (push) begin
          skid_d = push_res;
        end else begin
          skid_valid_d = 1'b0;
        end
      end else begin
        out_valid_d = push;
        out_d       = push_res;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = push_res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = push_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pass_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      pass_q       <= pass_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

@@ test/tb_insert_remove_sort_array.sv @@
// Testbench for insert_remove_sort_array: drives array operations on a valid/ready
// channel and checks every result against an in-bench model of the word store.
// Depends on irsa_pkg and the insert_remove_sort_array RTL.
`timescale 1ns / 1ps

module tb_insert_remove_sort_array;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         mode_i;
  logic [4:0]         position_i;
  logic signed [31:0] item_value_i;
  logic [4:0]         new_length_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] read_value_o;
  logic [4:0]         length_now_o;
  logic [1:0]         status_o;

  // Model of the store and the results still owed by the block
  logic signed [31:0] word_q [irsa_pkg::DEPTH];
  int                 fill_q;
  irsa_pkg::res_t     pending_results[$];

  int error_count;
  int in_gap_max;
  int out_stall_max;
  int idle_cycles;

  insert_remove_sort_array DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .new_length_i (new_length_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .length_now_o (length_now_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string msg);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic logic [1:0] insert_word(input int pos, input logic signed [31:0] val);
    int k;
    if (pos > fill_q) return irsa_pkg::STAT_RANGE;
    if (fill_q >= irsa_pkg::DEPTH) return irsa_pkg::STAT_FULL;
    for (k = fill_q; k > pos; k--) word_q[k] = word_q[k - 1];
    word_q[pos] = val;
    fill_q++;
    return irsa_pkg::STAT_OK;
  endfunction

  // Apply one operation to the model store and return the result it owes
  function automatic irsa_pkg::res_t predict_array_op(input logic [2:0] mode,
                                                      input logic [4:0] pos,
                                                      input logic signed [31:0] val,
                                                      input logic [4:0] nlen);
    irsa_pkg::res_t     r;
    logic signed [31:0] v;
    int                 k;
    int                 j;
    r.read_value = '0;
    r.status = irsa_pkg::STAT_OK;
    case (mode)
      irsa_pkg::MODE_WRITE: begin
        if (pos < fill_q) word_q[pos] = val;
        else r.status = irsa_pkg::STAT_RANGE;
      end
      irsa_pkg::MODE_READ: begin
        if (pos < fill_q) r.read_value = word_q[pos];
        else r.status = irsa_pkg::STAT_RANGE;
      end
      irsa_pkg::MODE_INSERT: r.status = insert_word(int'(pos), val);
      irsa_pkg::MODE_REMOVE: begin
        if (pos < fill_q) begin
          for (k = pos; k + 1 < fill_q; k++) word_q[k] = word_q[k + 1];
          fill_q--;
          word_q[fill_q] = '0;
        end else begin
          r.status = irsa_pkg::STAT_RANGE;
        end
      end
      irsa_pkg::MODE_PUSH: r.status = insert_word(fill_q, val);
      irsa_pkg::MODE_RESIZE: begin
        if (nlen > irsa_pkg::DEPTH) begin
          r.status = irsa_pkg::STAT_RANGE;
        end else begin
          for (k = fill_q; k < nlen; k++) word_q[k] = '0;
          fill_q = nlen;
        end
      end
      irsa_pkg::MODE_CLEAR: fill_q = 0;
      default: begin
        // ascending signed order; ties are indistinguishable
        for (k = 1; k < fill_q; k++) begin
          v = word_q[k];
          j = k;
          while (j > 0 && word_q[j - 1] > v) begin
            word_q[j] = word_q[j - 1];
            j--;
          end
          word_q[j] = v;
        end
      end
    endcase
    r.length_now = 5'(fill_q);
    return r;
  endfunction

  // Present one item after a random gap, hold it until the transfer, then record it
  task automatic send_item(input logic [2:0] mode, input logic [4:0] pos,
                           input logic signed [31:0] val, input logic [4:0] nlen);
    int             gap;
    irsa_pkg::res_t owed;
    gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    mode_i       = mode;
    position_i   = pos;
    item_value_i = val;
    new_length_i = nlen;
    do @(posedge clk_i); while (!in_ready_o);
    owed = predict_array_op(mode, pos, val, nlen);
    pending_results = {pending_results, owed};
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] pick_position();
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, fill_q));
  endfunction

  function automatic logic [4:0] pick_length();
    if ($urandom_range(0, 5) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, irsa_pkg::DEPTH));
  endfunction

  task automatic send_random(input int grow_pct);
    logic [2:0] mode;
    if ($urandom_range(0, 99) < grow_pct)
      mode = $urandom_range(0, 1) ? irsa_pkg::MODE_PUSH : irsa_pkg::MODE_INSERT;
    else mode = 3'($urandom_range(0, 7));
    send_item(mode, pick_position(), pick_word(), pick_length());
  endtask

  task automatic test_directed_cases();
    send_item(irsa_pkg::MODE_READ,   5'd0,  32'sd0,         5'd0);   // read of empty store
    send_item(irsa_pkg::MODE_WRITE,  5'd0,  32'sd5,         5'd0);   // write of empty store
    send_item(irsa_pkg::MODE_REMOVE, 5'd0,  32'sd0,         5'd0);   // remove from empty store
    send_item(irsa_pkg::MODE_SORT,   5'd0,  32'sd0,         5'd0);   // sort with nothing held
    send_item(irsa_pkg::MODE_PUSH,   5'd31, 32'sh7fff_ffff, 5'd31);
    send_item(irsa_pkg::MODE_PUSH,   5'd0,  32'sh8000_0000, 5'd0);
    send_item(irsa_pkg::MODE_INSERT, 5'd0,  -32'sd1,        5'd0);
    send_item(irsa_pkg::MODE_INSERT, 5'd31, 32'sd9,         5'd0);   // insert past the end
    send_item(irsa_pkg::MODE_INSERT, 5'd3,  32'sd0,         5'd0);   // insert exactly at the end
    send_item(irsa_pkg::MODE_WRITE,  5'd1,  32'sh5555_aaaa, 5'd0);
    send_item(irsa_pkg::MODE_READ,   5'd1,  32'sd0,         5'd0);
    send_item(irsa_pkg::MODE_READ,   5'd4,  32'sd0,         5'd0);   // read just past the end
    send_item(irsa_pkg::MODE_SORT,   5'd0,  32'sd0,         5'd0);
    send_item(irsa_pkg::MODE_RESIZE, 5'd0,  32'sd0,         5'd16);  // grow to capacity
    send_item(irsa_pkg::MODE_PUSH,   5'd0,  32'sd1,         5'd0);   // push into full store
    send_item(irsa_pkg::MODE_INSERT, 5'd16, 32'sd1,         5'd0);   // insert at end when full
    send_item(irsa_pkg::MODE_INSERT, 5'd17, 32'sd1,         5'd0);   // range check wins
    send_item(irsa_pkg::MODE_RESIZE, 5'd0,  32'sd0,         5'd17);  // above capacity
    send_item(irsa_pkg::MODE_SORT,   5'd0,  32'sd0,         5'd0);
    send_item(irsa_pkg::MODE_READ,   5'd15, 32'sd0,         5'd0);
    send_item(irsa_pkg::MODE_REMOVE, 5'd15, 32'sd0,         5'd0);   // remove the top element
    send_item(irsa_pkg::MODE_RESIZE, 5'd0,  32'sd0,         5'd15);  // same length
    send_item(irsa_pkg::MODE_RESIZE, 5'd0,  32'sd0,         5'd3);   // shrink keeps low part
    send_item(irsa_pkg::MODE_CLEAR,  5'd7,  32'sd7,         5'd7);
    send_item(irsa_pkg::MODE_RESIZE, 5'd0,  32'sd0,         5'd5);   // regrow reads back zero
    send_item(irsa_pkg::MODE_READ,   5'd4,  32'sd0,         5'd0);
  endtask

  task automatic test_random_mix(input int count, input int grow_pct);
    repeat (count) send_random(grow_pct);
  endtask

  // Load a random number of words, sort, then read back every element and one past the end
  task automatic test_fill_sort_readback(input int rounds);
    int n;
    int k;
    repeat (rounds) begin
      n = $urandom_range(0, irsa_pkg::DEPTH + 1);
      send_item(irsa_pkg::MODE_CLEAR, pick_position(), pick_word(), pick_length());
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_item(irsa_pkg::MODE_INSERT, pick_position(), pick_word(), 5'd0);
        else send_item(irsa_pkg::MODE_PUSH, pick_position(), pick_word(), pick_length());
      end
      send_item(irsa_pkg::MODE_SORT, pick_position(), pick_word(), pick_length());
      for (k = 0; k <= fill_q; k++)
        send_item(irsa_pkg::MODE_READ, 5'(k), pick_word(), pick_length());
    end
  endtask

  // Hold the sender until every owed result has been taken
  task automatic test_drain_pause(input int rounds, input int per_round);
    repeat (rounds) begin
      test_random_mix(per_round, 30);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      while (pending_results.size() > 0) @(posedge clk_i);
    end
  endtask

  // Result side: random stalls on ready, one check per transfer
  initial begin
    int             stall;
    irsa_pkg::res_t want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = (out_stall_max > 0) ? $urandom_range(0, out_stall_max) : 0;
      @(negedge clk_i);
      repeat (stall) begin
        out_ready_i = 1'b0;
        @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: value %0d length %0d status %0d",
                                read_value_o, length_now_o, status_o));
      end else begin
        want = pending_results.pop_front();
        if (read_value_o !== want.read_value)
          flag_mismatch($sformatf("read_value got %0d want %0d",
                                  read_value_o, $signed(want.read_value)));
        if (length_now_o !== want.length_now)
          flag_mismatch($sformatf("length_now got %0d want %0d", length_now_o, want.length_now));
        if (status_o !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
      end
    end
  end

  // Abort when neither channel has moved for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = irsa_pkg::MODE_WRITE;
    position_i    = '0;
    item_value_i  = '0;
    new_length_i  = '0;
    error_count   = 0;
    idle_cycles   = 0;
    in_gap_max    = 15;
    out_stall_max = 15;
    fill_q        = 0;
    for (k = 0; k < irsa_pkg::DEPTH; k++) word_q[k] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_mix(500, 20);
    test_fill_sort_readback(25);
    in_gap_max    = 0;
    out_stall_max = 0;
    test_random_mix(300, 25);
    in_gap_max = 15;
    test_random_mix(200, 40);
    in_gap_max    = 0;
    out_stall_max = 15;
    test_random_mix(200, 40);
    in_gap_max = 15;
    test_drain_pause(4, 50);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/irsa_pkg.sv
src/irsa_cell.sv
src/irsa_ctrl.sv
src/insert_remove_sort_array.sv
test/tb_insert_remove_sort_array.sv
